/* design/tbc_pkg.sv */
// Shared widths, types and constants of the barycentric coordinate pipeline.
package tbc_pkg;

   localparam int CW    = 32;          // coordinate and weight width
   localparam int DW    = CW + 1;      // vertex difference, signed
   localparam int MW    = CW;          // difference magnitude
   localparam int PW    = 2 * MW;      // first-level product magnitude
   localparam int SPW   = PW + 1;      // signed first-level product
   localparam int DOTW  = SPW + 2;     // dot product, signed
   localparam int DMW   = DOTW - 1;    // dot product magnitude
   localparam int LW    = 22;          // limb width of the wide multipliers
   localparam int NL    = 3;           // limbs per wide operand
   localparam int PPW   = 2 * LW;      // partial product
   localparam int PRW   = 2 * DMW;     // second-level product magnitude
   localparam int SPRW  = PRW + 1;     // signed second-level product
   localparam int NW3   = SPRW + 1;    // determinant and numerators b, c
   localparam int TW1   = NW3 + 1;     // det - nb
   localparam int NAW   = TW1 + 1;     // numerator a
   localparam int NMW   = NAW - 1;     // numerator magnitude
   localparam int FRAC  = 16;          // fraction bits of the weights
   localparam int XW    = NMW + FRAC + 2;  // dividend, |N| * 2^17 + D
   localparam int YW    = PRW + 1;     // divisor, 2 * D
   localparam int QB    = CW + 1;      // quotient bits kept
   localparam int TW    = YW + QB;     // trial compare width
   localparam int DIV_LAT = QB + 1;    // divider latency in cycles

   typedef logic signed [CW-1:0] coord_type;
   typedef logic [XW-1:0]        dividend_type;
   typedef logic [YW-1:0]        divisor_type;
   typedef logic [QB-1:0]        quotient_type;

   typedef struct packed {
      logic [2:0] neg;     // result sign of each weight
      logic       degen;   // zero determinant
   } side_type;

   localparam coord_type SAT_POS = 32'sh7FFF_FFFF;
   localparam coord_type SAT_NEG = 32'sh8000_0000;

endpackage

/* design/tbc_div.sv */
// Pipelined restoring divider: one quotient bit per stage, with overflow check.
module tbc_div (
   input  logic                  clock,
   input  tbc_pkg::dividend_type x,
   input  tbc_pkg::divisor_type  y,
   output tbc_pkg::quotient_type quo,
   output logic                  ovf
);
   import tbc_pkg::*;

   logic [XW-1:0] r_ff   [QB];
   logic [YW-1:0] y_ff   [QB];
   logic [QB-1:0] q_ff   [QB+1];
   logic          ovf_ff [QB+1];
   logic [TW-1:0] trial  [QB];
   logic          hit    [QB];
   logic [XW-1:0] r_in   [QB-1];
   logic          ovf_in;

   // quotient would need more than QB bits
   assign ovf_in = TW'(x) >= (TW'(y) << QB);

   always_comb begin
      for (int i = 0; i < QB; i++) begin
         trial[i] = TW'(y_ff[i]) << (QB - 1 - i);
         hit[i]   = TW'(r_ff[i]) >= trial[i];
      end
      for (int i = 0; i < QB - 1; i++) begin
         r_in[i] = hit[i] ? XW'(TW'(r_ff[i]) - trial[i]) : r_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      r_ff[0]   <= x;
      y_ff[0]   <= y;
      q_ff[0]   <= '0;
      ovf_ff[0] <= ovf_in;
      for (int i = 0; i < QB - 1; i++) begin
         r_ff[i+1] <= r_in[i];
         y_ff[i+1] <= y_ff[i];
      end
      for (int i = 0; i < QB; i++) begin
         q_ff[i+1]   <= {q_ff[i][QB-2:0], hit[i]};
         ovf_ff[i+1] <= ovf_ff[i];
      end
   end

   assign quo = q_ff[QB];
   assign ovf = ovf_ff[QB];

endmodule

/* design/triangle_barycentric_coords.sv */
// Top level of the barycentric coordinate pipeline for 3D triangles.
//
// Barycentric weights of a query point Q against a triangle A, B, C, all in
// signed Q16.16. One request enters on every clock edge where start is high
// and busy is low; busy is high only during reset. Each request yields one
// response on the rsp_ ports, marked by rsp_strobe for a single cycle, in
// request order. The depth is set by the arithmetic chain: 15 stages of
// differences, 32x32 products, dot sums, limb-split 66x66 products and
// numerator sums, then a 34-stage divider that resolves one quotient bit
// per stage, then the output register. The receiver cannot hold responses
// off, so the pipeline never stalls. Weights are rounded to nearest (ties
// away from zero) and saturate to the 32-bit range; a zero determinant sets
// rsp_degenerate and forces all three weights to zero.
module triangle_barycentric_coords (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  tbc_pkg::coord_type req_a_x,
   input  tbc_pkg::coord_type req_a_y,
   input  tbc_pkg::coord_type req_a_z,
   input  tbc_pkg::coord_type req_b_x,
   input  tbc_pkg::coord_type req_b_y,
   input  tbc_pkg::coord_type req_b_z,
   input  tbc_pkg::coord_type req_c_x,
   input  tbc_pkg::coord_type req_c_y,
   input  tbc_pkg::coord_type req_c_z,
   input  tbc_pkg::coord_type req_q_x,
   input  tbc_pkg::coord_type req_q_y,
   input  tbc_pkg::coord_type req_q_z,
   output logic               rsp_strobe,
   output tbc_pkg::coord_type rsp_weight_a,
   output tbc_pkg::coord_type rsp_weight_b,
   output tbc_pkg::coord_type rsp_weight_c,
   output logic               rsp_degenerate
);
   import tbc_pkg::*;

   localparam int LAT = 15 + DIV_LAT + 1;

   // operand selection of the five dot products: d11, d12, d22, dp1, dp2
   // vectors: 0 = e1, 1 = e2, 2 = p
   localparam int OPA [5] = '{0, 0, 1, 2, 2};
   localparam int OPB [5] = '{0, 1, 1, 0, 1};
   // operand selection of the six wide products over the dot products:
   // d11*d22, d12*d12, d22*dp1, d12*dp2, d11*dp2, d12*dp1
   localparam int OPC [6] = '{0, 1, 2, 1, 0, 1};
   localparam int OPD [6] = '{2, 1, 3, 4, 4, 3};

   // ---------------------------------------------------------------- control
   logic           vld_ff [LAT];
   logic           accept;

   assign busy   = reset;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) vld_ff[i] <= 1'b0;
      end else begin
         vld_ff[0] <= accept;
         for (int i = 1; i < LAT; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   // ---------------------------------------------------------- datapath regs
   coord_type                 va [3];
   coord_type                 vb [3][3];
   logic signed [DW-1:0]      vec_in  [3][3];
   logic signed [DW-1:0]      vec_ff  [3][3];
   logic [MW-1:0]             mag_in  [3][3];
   logic [MW-1:0]             mag_ff  [3][3];
   logic                      sgn_ff  [3][3];
   logic [PW-1:0]             prod_ff [5][3];
   logic                      psgn_ff [5][3];
   logic signed [SPW-1:0]     sprod_ff [5][3];
   logic signed [DOTW-1:0]    dot_in  [5];
   logic signed [DOTW-1:0]    dot_ff  [5];
   logic [DMW-1:0]            dmag_ff [5];
   logic                      dsgn_ff [5];
   logic [PPW-1:0]            pp_ff   [6][NL][NL];
   logic                      ms1_ff  [6];
   logic [PRW-1:0]            row_in  [6][NL];
   logic [PRW-1:0]            row_ff  [6][NL];
   logic                      ms2_ff  [6];
   logic [PRW-1:0]            mp_in   [6];
   logic [PRW-1:0]            mp_ff   [6];
   logic                      ms3_ff  [6];
   logic signed [SPRW-1:0]    smp_ff  [6];
   logic signed [NW3-1:0]     det_ff, nb_ff, nc_ff;
   logic signed [TW1-1:0]     t_ff;
   logic signed [NW3-1:0]     det12_ff, nb12_ff, nc12_ff;
   logic signed [NAW-1:0]     na_ff;
   logic signed [NW3-1:0]     det13_ff, nb13_ff, nc13_ff;
   logic signed [NAW-1:0]     num [3];
   logic [NMW-1:0]            nmag_ff [3];
   logic                      nneg_ff [3];
   logic [PRW-1:0]            den_ff;
   logic                      degen14_ff;
   dividend_type              x_ff [3];
   divisor_type               y_ff;
   side_type                  side15_ff;
   side_type                  side_ff [DIV_LAT];
   quotient_type              quo [3];
   logic                      ovf [3];
   coord_type                 wgt_in [3];
   coord_type                 wgt_ff [3];
   logic                      degen_ff;

   always_comb begin
      va    = '{req_a_x, req_a_y, req_a_z};
      vb[0] = '{req_b_x, req_b_y, req_b_z};
      vb[1] = '{req_c_x, req_c_y, req_c_z};
      vb[2] = '{req_q_x, req_q_y, req_q_z};
      for (int v = 0; v < 3; v++) begin
         for (int k = 0; k < 3; k++) begin
            vec_in[v][k] = DW'(vb[v][k]) - DW'(va[k]);
            mag_in[v][k] = MW'(vec_ff[v][k][DW-1] ? -vec_ff[v][k] : vec_ff[v][k]);
         end
      end
      for (int d = 0; d < 5; d++) begin
         dot_in[d] = DOTW'(sprod_ff[d][0]) + DOTW'(sprod_ff[d][1])
                   + DOTW'(sprod_ff[d][2]);
      end
      // wide products: sum the limb partial products by rows, then the rows
      for (int m = 0; m < 6; m++) begin
         for (int i = 0; i < NL; i++) begin
            row_in[m][i] = '0;
            for (int j = 0; j < NL; j++) begin
               row_in[m][i] = row_in[m][i] + (PRW'(pp_ff[m][i][j]) << (LW * j));
            end
         end
         mp_in[m] = '0;
         for (int i = 0; i < NL; i++) begin
            mp_in[m] = mp_in[m] + (row_ff[m][i] << (LW * i));
         end
      end
      num[0] = na_ff;
      num[1] = NAW'(nb13_ff);
      num[2] = NAW'(nc13_ff);
   end

   always_ff @(posedge clock) begin
      // differences, magnitudes, 32x32 products
      for (int v = 0; v < 3; v++) begin
         for (int k = 0; k < 3; k++) begin
            vec_ff[v][k] <= vec_in[v][k];
            mag_ff[v][k] <= mag_in[v][k];
            sgn_ff[v][k] <= vec_ff[v][k][DW-1];
         end
      end
      for (int d = 0; d < 5; d++) begin
         for (int k = 0; k < 3; k++) begin
            prod_ff[d][k]  <= mag_ff[OPA[d]][k] * mag_ff[OPB[d]][k];
            psgn_ff[d][k]  <= sgn_ff[OPA[d]][k] ^ sgn_ff[OPB[d]][k];
            sprod_ff[d][k] <= psgn_ff[d][k] ? -SPW'(prod_ff[d][k]) : SPW'(prod_ff[d][k]);
         end
         dot_ff[d]  <= dot_in[d];
         dmag_ff[d] <= DMW'(dot_ff[d][DOTW-1] ? -dot_ff[d] : dot_ff[d]);
         dsgn_ff[d] <= dot_ff[d][DOTW-1];
      end
      // limb-split wide products
      for (int m = 0; m < 6; m++) begin
         for (int i = 0; i < NL; i++) begin
            for (int j = 0; j < NL; j++) begin
               pp_ff[m][i][j] <= dmag_ff[OPC[m]][i*LW +: LW] * dmag_ff[OPD[m]][j*LW +: LW];
            end
            row_ff[m][i] <= row_in[m][i];
         end
         ms1_ff[m] <= dsgn_ff[OPC[m]] ^ dsgn_ff[OPD[m]];
         ms2_ff[m] <= ms1_ff[m];
         mp_ff[m]  <= mp_in[m];
         ms3_ff[m] <= ms2_ff[m];
         smp_ff[m] <= ms3_ff[m] ? -SPRW'(mp_ff[m]) : SPRW'(mp_ff[m]);
      end
      // determinant and numerators
      det_ff   <= NW3'(smp_ff[0]) - NW3'(smp_ff[1]);
      nb_ff    <= NW3'(smp_ff[2]) - NW3'(smp_ff[3]);
      nc_ff    <= NW3'(smp_ff[4]) - NW3'(smp_ff[5]);
      t_ff     <= TW1'(det_ff) - TW1'(nb_ff);
      det12_ff <= det_ff;
      nb12_ff  <= nb_ff;
      nc12_ff  <= nc_ff;
      na_ff    <= NAW'(t_ff) - NAW'(nc12_ff);
      det13_ff <= det12_ff;
      nb13_ff  <= nb12_ff;
      nc13_ff  <= nc12_ff;
      // magnitudes; the Gram determinant is never negative
      for (int l = 0; l < 3; l++) begin
         nmag_ff[l] <= NMW'(num[l][NAW-1] ? -num[l] : num[l]);
         nneg_ff[l] <= num[l][NAW-1];
         // fold round-half-up into the dividend: (|N| * 2^17 + D) / (2 * D)
         x_ff[l]    <= (XW'(nmag_ff[l]) << (FRAC + 1)) + XW'(den_ff);
      end
      den_ff     <= PRW'(det13_ff);
      degen14_ff <= (det13_ff == '0);
      y_ff       <= {den_ff, 1'b0};
      side15_ff.neg   <= {nneg_ff[2], nneg_ff[1], nneg_ff[0]};
      side15_ff.degen <= degen14_ff;
      // carry signs and flag alongside the divider
      side_ff[0] <= side15_ff;
      for (int i = 1; i < DIV_LAT; i++) side_ff[i] <= side_ff[i-1];
      for (int l = 0; l < 3; l++) wgt_ff[l] <= wgt_in[l];
      degen_ff <= side_ff[DIV_LAT-1].degen;
   end

   // ---------------------------------------------------------------- divide
   for (genvar l = 0; l < 3; l++) begin : g_lane
      tbc_div u_div (
         .clock (clock),
         .x     (x_ff[l]),
         .y     (y_ff),
         .quo   (quo[l]),
         .ovf   (ovf[l])
      );
   end

   // apply sign, saturate, force zero on a degenerate triangle
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         if (side_ff[DIV_LAT-1].degen) begin
            wgt_in[l] = '0;
         end else if (!side_ff[DIV_LAT-1].neg[l]) begin
            wgt_in[l] = (ovf[l] || quo[l] > QB'(SAT_POS)) ? SAT_POS : CW'(quo[l]);
         end else begin
            wgt_in[l] = (ovf[l] || quo[l] > {1'b0, SAT_NEG}) ? SAT_NEG : CW'(-quo[l]);
         end
      end
   end

   assign rsp_strobe     = vld_ff[LAT-1];
   assign rsp_weight_a   = wgt_ff[0];
   assign rsp_weight_b   = wgt_ff[1];
   assign rsp_weight_c   = wgt_ff[2];
   assign rsp_degenerate = degen_ff;

`ifndef ASSERT_OFF
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_degenerate |->
         rsp_weight_a == '0 && rsp_weight_b == '0 && rsp_weight_c == '0)
      else $error("degenerate response carries nonzero weights");

   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##LAT rsp_strobe)
      else $error("accepted request produced no response");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LAT))
      else $error("response without a matching request");
`endif

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the barycentric coordinate pipeline.
//
// Requests carry a triangle A, B, C and a query point Q in signed Q16.16.
// Every accepted request is handed to a scoreboard object. It predicts the
// three weights and the degenerate flag with exact wide integer arithmetic
// and queues them. Each strobed response is then checked, field by field,
// against the oldest queued prediction. The stimulus begins with a directed
// set: degenerate shapes, unit triangles, coordinate extremes and saturating
// queries. A long random phase follows. Most of it is well-formed small
// triangles with the query nearby; the rest is full-range noise and
// collinear or coincident vertices. The sender idles for random gaps between
// requests.
module tb_top;
   import tbc_pkg::*;

   typedef logic signed [255:0] wide_type;

   // one request: vertices A, B, C then query Q, each x, y, z
   typedef struct {
      coord_type v[12];
   } query_type;

   typedef struct {
      coord_type wa;
      coord_type wb;
      coord_type wc;
      logic      degen;
   } weights_type;

   // Predict the expected weights and check the responses in request order.
   class weight_board;
      weights_type pending[$];
      int unsigned errors;
      int unsigned checked;
      int unsigned degens;

      // round(num * 2^16 / den), ties away from zero, saturated
      function automatic coord_type ratio(wide_type num, wide_type den);
         logic     neg;
         wide_type nm, dm, q;
         neg = num[255] ^ den[255];
         nm = num[255] ? -num : num;
         dm = den[255] ? -den : den;
         q = ((nm <<< 17) + dm) / (dm <<< 1);
         if (!neg) begin
            if (q > wide_type'(64'h7FFF_FFFF)) return SAT_POS;
            return coord_type'(q);
         end
         if (q > wide_type'(64'h8000_0000)) return SAT_NEG;
         return coord_type'(-q);
      endfunction

      function automatic wide_type dot(wide_type u[3], wide_type w[3]);
         return u[0] * w[0] + u[1] * w[1] + u[2] * w[2];
      endfunction

      function void note(query_type r);
         wide_type    e1[3], e2[3], p[3];
         wide_type    d11, d12, d22, dp1, dp2, det, nb, nc, na;
         weights_type w;
         for (int k = 0; k < 3; k++) begin
            e1[k] = wide_type'(r.v[3 + k]) - wide_type'(r.v[k]);
            e2[k] = wide_type'(r.v[6 + k]) - wide_type'(r.v[k]);
            p[k]  = wide_type'(r.v[9 + k]) - wide_type'(r.v[k]);
         end
         d11 = dot(e1, e1);
         d12 = dot(e1, e2);
         d22 = dot(e2, e2);
         dp1 = dot(p, e1);
         dp2 = dot(p, e2);
         det = d11 * d22 - d12 * d12;
         if (det == 0) begin
            w = '{wa: '0, wb: '0, wc: '0, degen: 1'b1};
         end else begin
            nb = d22 * dp1 - d12 * dp2;
            nc = d11 * dp2 - d12 * dp1;
            na = det - nb - nc;
            w = '{wa: ratio(na, det), wb: ratio(nb, det), wc: ratio(nc, det),
                  degen: 1'b0};
         end
         pending.insert(pending.size(), w);
      endfunction

      function void check(weights_type got);
         weights_type x;
         if (pending.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
            return;
         end
         x = pending.pop_front();
         checked++;
         if (got.degen) degens++;
         if (got.wa !== x.wa) begin
            $error("weight_a expected %h actual %h", x.wa, got.wa);
            errors++;
         end
         if (got.wb !== x.wb) begin
            $error("weight_b expected %h actual %h", x.wb, got.wb);
            errors++;
         end
         if (got.wc !== x.wc) begin
            $error("weight_c expected %h actual %h", x.wc, got.wc);
            errors++;
         end
         if (got.degen !== x.degen) begin
            $error("degenerate expected %b actual %b", x.degen, got.degen);
            errors++;
         end
      endfunction
   endclass

   localparam int RANDOM_REQUESTS = 1730;
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int DRAIN_CYCLES    = 60;

   logic      clock, reset, start, busy;
   coord_type req[12];
   logic      rsp_strobe, rsp_degenerate;
   coord_type rsp_weight_a, rsp_weight_b, rsp_weight_c;

   weight_board board;
   int unsigned sent;
   int unsigned idle_cycles;

   triangle_barycentric_coords dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_a_x(req[0]), .req_a_y(req[1]), .req_a_z(req[2]),
      .req_b_x(req[3]), .req_b_y(req[4]), .req_b_z(req[5]),
      .req_c_x(req[6]), .req_c_y(req[7]), .req_c_z(req[8]),
      .req_q_x(req[9]), .req_q_y(req[10]), .req_q_z(req[11]),
      .rsp_strobe(rsp_strobe),
      .rsp_weight_a(rsp_weight_a), .rsp_weight_b(rsp_weight_b),
      .rsp_weight_c(rsp_weight_c), .rsp_degenerate(rsp_degenerate)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Sample both channels on the edge; values seen here are the pre-edge ones.
   always @(posedge clock) begin
      if (!reset && start && !busy) board.note('{v: req});
      if (!reset && rsp_strobe)
         board.check('{wa: rsp_weight_a, wb: rsp_weight_b, wc: rsp_weight_c,
                       degen: rsp_degenerate});
   end

   // Count cycles where neither channel moves; a stuck pipeline ends the run.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no activity for %0d cycles", idle_cycles);
            $display("tb_top: done, errors");
            $finish;
         end
      end
   end

   // Mostly short gaps, a few long ones, and runs of back-to-back requests.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Present one request, hold it until accepted, then idle for a gap.
   task automatic send(query_type r);
      int gap;
      start <= 1'b1;
      for (int k = 0; k < 12; k++) req[k] <= r.v[k];
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
      sent++;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic coord_type near(coord_type base, int span);
      return base + coord_type'($urandom_range(0, 2 * span) - span);
   endfunction

   function automatic query_type make_query(coord_type a[3], coord_type b[3],
                                            coord_type c[3], coord_type q[3]);
      query_type r;
      for (int k = 0; k < 3; k++) begin
         r.v[k] = a[k];
         r.v[3 + k] = b[k];
         r.v[6 + k] = c[k];
         r.v[9 + k] = q[k];
      end
      return r;
   endfunction

   // Well-formed small triangle with the query close by.
   function automatic query_type well_formed();
      coord_type a[3], b[3], c[3], q[3];
      int        span;
      span = (1 << $urandom_range(4, 20));
      for (int k = 0; k < 3; k++) begin
         a[k] = coord_type'($urandom_range(0, 1 << 25)) - coord_type'(1 << 24);
         b[k] = near(a[k], span);
         c[k] = near(a[k], span);
         q[k] = near(a[k], 2 * span);
      end
      return make_query(a, b, c, q);
   endfunction

   function automatic query_type full_range();
      query_type r;
      for (int k = 0; k < 12; k++) r.v[k] = coord_type'($urandom);
      return r;
   endfunction

   // Collinear (C on line AB) or coincident vertices; both zero the determinant.
   function automatic query_type flat_shape();
      coord_type a[3], b[3], c[3], q[3];
      int        m;
      m = int'($urandom_range(0, 6)) - 3;
      for (int k = 0; k < 3; k++) begin
         a[k] = coord_type'($urandom_range(0, 1 << 20)) - coord_type'(1 << 19);
         b[k] = near(a[k], 1 << 16);
         c[k] = a[k] + coord_type'(m) * (b[k] - a[k]);
         q[k] = coord_type'($urandom);
      end
      if ($urandom_range(0, 1)) begin
         b = a;
         c = a;
      end
      return make_query(a, b, c, q);
   endfunction

   task automatic run_directed();
      localparam coord_type ONE = 32'sh0001_0000;
      coord_type z[3], ex[3], ey[3], ez[3], mx[3], mn[3], q[3];
      query_type r;
      z  = '{0, 0, 0};
      ex = '{ONE, 0, 0};
      ey = '{0, ONE, 0};
      ez = '{0, 0, ONE};
      mx = '{SAT_POS, SAT_POS, SAT_POS};
      mn = '{SAT_NEG, SAT_NEG, SAT_NEG};
      // all-zero request: coincident vertices
      send(make_query(z, z, z, z));
      // unit right triangle, query on each vertex and the centroid
      send(make_query(z, ex, ey, z));
      send(make_query(z, ex, ey, ex));
      send(make_query(z, ex, ey, ey));
      q = '{32'sh0000_5555, 32'sh0000_5555, 0};
      send(make_query(z, ex, ey, q));
      // query off the plane, projected in
      send(make_query(ex, ey, ez, mx));
      // query far outside: weights saturate both ways
      send(make_query(z, ex, ey, mx));
      send(make_query(z, ex, ey, mn));
      // coordinate extremes for the vertices
      send(make_query(mn, mx, '{SAT_NEG, SAT_POS, 0}, z));
      send(make_query(mx, mn, '{0, SAT_NEG, SAT_POS}, mx));
      send(make_query(mn, '{SAT_POS, SAT_NEG, SAT_NEG}, '{SAT_NEG, SAT_POS, SAT_NEG}, mn));
      // collinear vertices: on the main diagonal, then on the x axis
      send(make_query(mn, z, mx, q));
      send(make_query(z, ex, '{2 * ONE, 0, 0}, ey));
      // tiny triangle: sides a single LSB long
      send(make_query(z, '{1, 0, 0}, '{0, 1, 0}, '{1, 1, 0}));
      send(make_query(z, '{1, 0, 0}, '{0, 1, 0}, '{-1, -1, -1}));
      // full-range random requests, then one flat shape
      for (int i = 0; i < 6; i++) begin
         r = full_range();
         send(r);
      end
      r = flat_shape();
      send(r);
   endtask

   initial begin
      query_type r;
      int        pick;
      board = new();
      reset = 1'b1;
      start = 1'b0;
      for (int k = 0; k < 12; k++) req[k] = '0;
      sent = 0;
      idle_cycles = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();

      // Random phase: mostly well-formed geometry, some noise and flat shapes.
      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) r = well_formed();
         else if (pick < 9) r = full_range();
         else r = flat_shape();
         send(r);
      end
      start <= 1'b0;

      // Drain the pipeline, then allow some quiet cycles for strays.
      while (board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d requests, %0d responses checked, %0d degenerate",
               sent, board.checked, board.degens);
      $display("mix: directed extremes, small well-formed triangles, full-range noise");
      if (board.errors == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

/* sim.f */
design/tbc_pkg.sv
design/tbc_div.sv
design/triangle_barycentric_coords.sv
dv/tb_top.sv
